// ----- sv/tga_pkg.sv -----
// Shared types and codes for the TGA run-length decoder.
// No dependencies; every other file refers to it by scoped names.
package tga_pkg;

    localparam logic [2:0] KIND_HEADER      = 3'd0;
    localparam logic [2:0] KIND_SPAN        = 3'd1;
    localparam logic [2:0] KIND_UNSUPPORTED = 3'd2;
    localparam logic [2:0] KIND_TRUNCATED   = 3'd3;
    localparam logic [2:0] KIND_COMPLETE    = 3'd4;

    // header byte offsets and values
    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_CMAP     = 5'd1;
    localparam logic [4:0] HDR_TYPE     = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_BPP      = 5'd16;
    localparam logic [4:0] HDR_LAST     = 5'd17;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;
    localparam logic [7:0] BPP_24   = 8'd24;
    localparam logic [7:0] BPP_32   = 8'd32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] pixel_index;
        logic [7:0]  run_length;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last_of_step;
    } t_out;

    // results of one input byte; res1 is meaningful only when two is set
    typedef struct packed {
        t_out res0;
        t_out res1;
        logic two;
    } t_step;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ----- sv/tga_front.sv -----
// Byte parser: header checks, ID skip, packet and pixel assembly.
// Produces one step record of up to two results per byte. Uses tga_pkg.
module tga_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tga_pkg::t_in  i_in,
    input  logic          i_full,
    output logic          o_wr,
    output tga_pkg::t_step o_step
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_DRAIN
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_rle, n_rle;
    logic        r_bpp4, n_bpp4;
    logic [7:0]  r_id_left, n_id_left;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_remain, n_remain;
    logic [31:0] r_done, n_done;
    logic [7:0]  r_pkt, n_pkt;
    logic        r_run, n_run;
    logic [1:0]  r_comp, n_comp;
    logic [23:0] r_color, n_color;

    logic          accept;
    logic [7:0]    b;
    logic          bad;
    logic          start;
    logic          empty_img;
    logic [31:0]   prod;
    logic [23:0]   color_new;
    logic [1:0]    last_comp;
    logic [7:0]    len_raw;
    logic [7:0]    len;
    logic          hit_end;
    logic [1:0]    nres;
    tga_pkg::t_out res [2];

    function automatic tga_pkg::t_out mk(input logic [2:0] kind, input logic [23:0] color,
                                         input logic [31:0] idx, input logic [7:0] rl,
                                         input logic [15:0] w, input logic [15:0] h);
        tga_pkg::t_out r;
        r.kind         = kind;
        r.red          = color[23:16];
        r.green        = color[15:8];
        r.blue         = color[7:0];
        r.pixel_index  = idx;
        r.run_length   = rl;
        r.image_width  = w;
        r.image_height = h;
        r.last_of_step = 1'b0;
        return r;
    endfunction

    assign accept    = i_push && !i_full;
    assign b         = i_in.data_byte;
    assign prod      = {16'b0, r_width} * {16'b0, r_height};
    assign empty_img = (r_width == 16'd0) || (r_height == 16'd0);
    assign last_comp = r_bpp4 ? 2'd3 : 2'd2;

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_rle     = r_rle;
        n_bpp4    = r_bpp4;
        n_id_left = r_id_left;
        n_width   = r_width;
        n_height  = r_height;
        n_remain  = r_remain;
        n_done    = r_done;
        n_pkt     = r_pkt;
        n_run     = r_run;
        n_comp    = r_comp;
        n_color   = r_color;
        bad       = 1'b0;
        start     = 1'b0;
        color_new = r_color;
        len_raw   = 8'd1;
        len       = 8'd1;
        hit_end   = 1'b0;
        nres      = 2'd0;
        res[0]    = '0;
        res[1]    = '0;

        case (r_comp)
            2'd0:    color_new[7:0]   = b;
            2'd1:    color_new[15:8]  = b;
            2'd2:    color_new[23:16] = b;
            default: color_new        = r_color;
        endcase

        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    unique case (r_hdr_cnt)
                        tga_pkg::HDR_ID_LEN:    n_id_left = b;
                        tga_pkg::HDR_CMAP:      bad = (b != 8'd0);
                        tga_pkg::HDR_TYPE: begin
                            if (b == tga_pkg::TYPE_RAW)      n_rle = 1'b0;
                            else if (b == tga_pkg::TYPE_RLE) n_rle = 1'b1;
                            else                             bad = 1'b1;
                        end
                        tga_pkg::HDR_WIDTH_LO:  n_width[7:0]   = b;
                        tga_pkg::HDR_WIDTH_HI:  n_width[15:8]  = b;
                        tga_pkg::HDR_HEIGHT_LO: n_height[7:0]  = b;
                        tga_pkg::HDR_HEIGHT_HI: n_height[15:8] = b;
                        tga_pkg::HDR_BPP: begin
                            if (b == tga_pkg::BPP_24)      n_bpp4 = 1'b0;
                            else if (b == tga_pkg::BPP_32) n_bpp4 = 1'b1;
                            else                           bad = 1'b1;
                        end
                        default: ;
                    endcase
                    if (bad) begin
                        res[nres[0]] = mk(tga_pkg::KIND_UNSUPPORTED, 24'd0, 32'd0, 8'd0,
                                          16'd0, 16'd0);
                        nres    = nres + 2'd1;
                        n_phase = PH_DRAIN;
                    end else if (r_hdr_cnt != tga_pkg::HDR_LAST) begin
                        n_hdr_cnt = r_hdr_cnt + 5'd1;
                    end else begin
                        n_hdr_cnt = 5'd0;
                        n_remain  = prod;
                        n_done    = 32'd0;
                        res[nres[0]] = mk(tga_pkg::KIND_HEADER, 24'd0, 32'd0, 8'd0,
                                          r_width, r_height);
                        nres = nres + 2'd1;
                        if (r_id_left != 8'd0) n_phase = PH_SKIP;
                        else                   start = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (r_id_left != 8'd0) n_id_left = r_id_left - 8'd1;
                    if (n_id_left == 8'd0) start = 1'b1;
                end
                PH_PACKET: begin
                    n_pkt   = {1'b0, b[6:0]} + 8'd1;
                    n_run   = b[7];
                    n_comp  = 2'd0;
                    n_color = 24'd0;
                    n_phase = PH_PIXEL;
                end
                PH_PIXEL: begin
                    n_color = color_new;
                    if (r_comp != last_comp) begin
                        n_comp = r_comp + 2'd1;
                    end else begin
                        len_raw = (r_rle && r_run) ? r_pkt : 8'd1;
                        // clip against pixels left: remain is never zero here
                        hit_end = (r_remain[31:8] == 24'd0) && (r_remain[7:0] <= len_raw);
                        len     = hit_end ? r_remain[7:0] : len_raw;
                        res[nres[0]] = mk(tga_pkg::KIND_SPAN, color_new, r_done, len,
                                          16'd0, 16'd0);
                        nres     = nres + 2'd1;
                        n_done   = r_done + {24'd0, len};
                        n_remain = r_remain - {24'd0, len};
                        if (r_rle) begin
                            if (r_run)              n_pkt = 8'd0;
                            else if (r_pkt != 8'd0) n_pkt = r_pkt - 8'd1;
                        end
                        n_comp  = 2'd0;
                        n_color = 24'd0;
                        if (hit_end) begin
                            res[nres[0]] = mk(tga_pkg::KIND_COMPLETE, 24'd0, n_done, 8'd0,
                                              16'd0, 16'd0);
                            nres    = nres + 2'd1;
                            n_phase = PH_DRAIN;
                        end else if (r_rle && n_pkt == 8'd0) begin
                            n_phase = PH_PACKET;
                        end
                    end
                end
                default: ;
            endcase

            if (start) begin
                n_comp  = 2'd0;
                n_color = 24'd0;
                if (empty_img) begin
                    res[nres[0]] = mk(tga_pkg::KIND_COMPLETE, 24'd0, 32'd0, 8'd0,
                                      16'd0, 16'd0);
                    nres    = nres + 2'd1;
                    n_phase = PH_DRAIN;
                end else begin
                    n_phase = r_rle ? PH_PACKET : PH_PIXEL;
                    n_pkt   = 8'd0;
                    n_run   = 1'b0;
                end
            end

            if (i_in.end_of_file) begin
                if (n_phase != PH_DRAIN) begin
                    res[nres[0]] = mk(tga_pkg::KIND_TRUNCATED, 24'd0, n_done, 8'd0,
                                      16'd0, 16'd0);
                    nres = nres + 2'd1;
                end
                n_phase   = PH_HEADER;
                n_hdr_cnt = 5'd0;
                n_rle     = 1'b0;
                n_bpp4    = 1'b0;
                n_id_left = 8'd0;
                n_width   = 16'd0;
                n_height  = 16'd0;
                n_remain  = 32'd0;
                n_done    = 32'd0;
                n_pkt     = 8'd0;
                n_run     = 1'b0;
                n_comp    = 2'd0;
                n_color   = 24'd0;
            end
        end

        if (nres[1]) res[1].last_of_step = 1'b1;
        else         res[0].last_of_step = 1'b1;
    end

    assign o_wr        = accept && (nres != 2'd0);
    assign o_step.res0 = res[0];
    assign o_step.res1 = res[1];
    assign o_step.two  = nres[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 5'd0;
            r_rle     <= 1'b0;
            r_bpp4    <= 1'b0;
            r_id_left <= 8'd0;
            r_width   <= 16'd0;
            r_height  <= 16'd0;
            r_remain  <= 32'd0;
            r_done    <= 32'd0;
            r_pkt     <= 8'd0;
            r_run     <= 1'b0;
            r_comp    <= 2'd0;
            r_color   <= 24'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_rle     <= n_rle;
            r_bpp4    <= n_bpp4;
            r_id_left <= n_id_left;
            r_width   <= n_width;
            r_height  <= n_height;
            r_remain  <= n_remain;
            r_done    <= n_done;
            r_pkt     <= n_pkt;
            r_run     <= n_run;
            r_comp    <= n_comp;
            r_color   <= n_color;
        end
    end

endmodule

// ----- sv/tga_fifo.sv -----
// Short queue of step records between parser and result serializer.
// Register file with wrap-around pointers. Uses tga_pkg.
module tga_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  tga_pkg::t_step  i_wdata,
    input  logic            i_rd,
    output tga_pkg::t_step  o_rdata,
    output tga_pkg::t_q_stat o_stat
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   FULL_CNT  = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] PTR_ONE   = ADDR_W'(1);
    localparam logic [ADDR_W:0]   CNT_ONE   = (ADDR_W + 1)'(1);

    tga_pkg::t_step    r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [ADDR_W:0]   r_count;
    logic              do_wr, do_rd;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);
    assign do_wr   = i_wr && !o_stat.full;
    assign do_rd   = i_rd && !o_stat.empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wr_ptr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) r_wr_ptr <= (r_wr_ptr == LAST_ADDR) ? '0 : r_wr_ptr + PTR_ONE;
            if (do_rd) r_rd_ptr <= (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + PTR_ONE;
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + CNT_ONE;
                2'b01:   r_count <= r_count - CNT_ONE;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/tga_back.sv -----
// Result serializer: presents the one or two results of the head record
// in order and retires the record after its last result. Uses tga_pkg.
module tga_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tga_pkg::t_step   i_head,
    input  tga_pkg::t_q_stat i_stat,
    input  logic             i_pop,
    output logic             o_empty,
    output tga_pkg::t_out    o_out,
    output logic             o_rd
);

    logic r_slot;
    logic take;

    assign o_empty = i_stat.empty;
    assign o_out   = r_slot ? i_head.res1 : i_head.res0;
    assign take    = i_pop && !i_stat.empty;
    assign o_rd    = take && (r_slot || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 1'b0;
        end else if (take) begin
            r_slot <= i_head.two && !r_slot;
        end
    end

endmodule

// ----- sv/tga_rle_image_decoder.sv -----
// Throughput: one file byte per cycle while the queue is not full; results
// leave one per cycle on pop. A byte's results are queued behind earlier
// ones. A byte that gives two results holds its queue slot for two pops;
// full rises when DEPTH step records wait. Reset (synchronous, active low)
// empties the queue and returns the parser to awaiting a header.
module tga_rle_image_decoder #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  tga_pkg::t_in   i_in,
    output logic           o_empty,
    input  logic           i_pop,
    output tga_pkg::t_out  o_out
);

    logic             wr;
    logic             rd;
    tga_pkg::t_step   wdata;
    tga_pkg::t_step   head;
    tga_pkg::t_q_stat stat;

    assign o_full = stat.full;

    tga_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_in    (i_in),
        .i_full  (stat.full),
        .o_wr    (wr),
        .o_step  (wdata)
    );

    tga_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_wdata (wdata),
        .i_rd    (rd),
        .o_rdata (head),
        .o_stat  (stat)
    );

    tga_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (stat),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_out   (o_out),
        .o_rd    (rd)
    );

endmodule

// ----- sv/tga_chk.sv -----
// Port-level checker for the TGA decoder, bound to the top level.
// Uses tga_pkg.
module tga_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_push,
    input logic          o_full,
    input tga_pkg::t_in  i_in,
    input logic          o_empty,
    input logic          i_pop,
    input tga_pkg::t_out o_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out)))
        else $error("waiting result changed before pop");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queue not empty after reset");

    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.kind == tga_pkg::KIND_SPAN) |->
        (o_out.run_length != 8'd0 && o_out.image_width == 16'd0))
        else $error("span with zero length or stray size");

    a_nonspan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.kind != tga_pkg::KIND_SPAN) |->
        (o_out.run_length == 8'd0 && o_out.red == 8'd0 &&
         o_out.green == 8'd0 && o_out.blue == 8'd0))
        else $error("non-span result carries span data");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out.kind <= tga_pkg::KIND_COMPLETE))
        else $error("result kind out of range");

endmodule

bind tga_rle_image_decoder tga_chk u_chk (.*);

// ----- tb/sv/tga_rle_image_decoder_test.sv -----
// Self-checking bench for the streaming TGA run-length decoder.
// Needs tga_pkg and tga_rle_image_decoder; a directed table then random files,
// every popped word checked against the table row or a built-in decode model.
module tga_rle_image_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_SKIP_ID,
        ST_PACKET,
        ST_PIXEL,
        ST_IGNORE
    } t_dec_state;

    typedef struct {
        tga_pkg::t_in  word;
        logic          has_want;
        tga_pkg::t_out want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    tga_pkg::t_in  i_in = '0;
    logic o_full;
    logic o_empty;
    tga_pkg::t_out o_out;

    tga_rle_image_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_in    (i_in),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_out   (o_out)
    );

    // decode model state
    t_dec_state  dec_state;
    logic [4:0]  hdr_pos;
    logic        rle_mode;
    logic        four_bytes;
    logic [7:0]  id_left;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [31:0] pix_total;
    logic [31:0] pix_done;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [1:0]  comp_idx;
    logic [23:0] color_acc;

    tga_pkg::t_out byte_results[$];
    tga_pkg::t_out pending_results[$];
    t_dir_row      directed_rows[$];
    logic [7:0]    file_bytes[$];

    int   mismatch_count = 0;
    int   words_sent = 0;
    logic calm = 1'b0;
    logic push_high = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic void clear_decoder();
        dec_state = ST_HEADER;
        hdr_pos = '0;
        rle_mode = 1'b0;
        four_bytes = 1'b0;
        id_left = '0;
        img_w = '0;
        img_h = '0;
        pix_total = '0;
        pix_done = '0;
        pkt_left = '0;
        pkt_run = 1'b0;
        comp_idx = '0;
        color_acc = '0;
    endfunction

    function automatic void add_result(logic [2:0] kind, logic [23:0] color, logic [31:0] index,
                                       logic [7:0] len, logic [15:0] w, logic [15:0] h);
        tga_pkg::t_out r;
        if (byte_results.size() >= 2) return;
        r = '0;
        r.kind = kind;
        r.red = color[23:16];
        r.green = color[15:8];
        r.blue = color[7:0];
        r.pixel_index = index;
        r.run_length = len;
        r.image_width = w;
        r.image_height = h;
        byte_results.push_back(r);
    endfunction

    function automatic void enter_pixels();
        comp_idx = '0;
        color_acc = '0;
        if (pix_total == 0) begin
            add_result(tga_pkg::KIND_COMPLETE, '0, '0, '0, '0, '0);
            dec_state = ST_IGNORE;
        end else begin
            dec_state = rle_mode ? ST_PACKET : ST_PIXEL;
            pkt_left = '0;
            pkt_run = 1'b0;
        end
    endfunction

    function automatic void take_header_byte(logic [7:0] b);
        logic bad;
        bad = 1'b0;
        case (hdr_pos)
            tga_pkg::HDR_ID_LEN:    id_left = b;
            tga_pkg::HDR_CMAP:      bad = (b != 8'd0);
            tga_pkg::HDR_TYPE: begin
                if (b == tga_pkg::TYPE_RAW) rle_mode = 1'b0;
                else if (b == tga_pkg::TYPE_RLE) rle_mode = 1'b1;
                else bad = 1'b1;
            end
            tga_pkg::HDR_WIDTH_LO:  img_w[7:0] = b;
            tga_pkg::HDR_WIDTH_HI:  img_w[15:8] = b;
            tga_pkg::HDR_HEIGHT_LO: img_h[7:0] = b;
            tga_pkg::HDR_HEIGHT_HI: img_h[15:8] = b;
            tga_pkg::HDR_BPP: begin
                if (b == tga_pkg::BPP_24) four_bytes = 1'b0;
                else if (b == tga_pkg::BPP_32) four_bytes = 1'b1;
                else bad = 1'b1;
            end
            default: ;
        endcase
        if (bad) begin
            add_result(tga_pkg::KIND_UNSUPPORTED, '0, '0, '0, '0, '0);
            dec_state = ST_IGNORE;
            return;
        end
        if (hdr_pos < tga_pkg::HDR_LAST) begin
            hdr_pos = hdr_pos + 5'd1;
            return;
        end
        hdr_pos = '0;
        pix_total = {16'd0, img_w} * {16'd0, img_h};
        pix_done = '0;
        add_result(tga_pkg::KIND_HEADER, '0, '0, '0, img_w, img_h);
        if (id_left != 0) dec_state = ST_SKIP_ID;
        else enter_pixels();
    endfunction

    function automatic void take_pixel_byte(logic [7:0] b);
        logic [1:0]  last_comp;
        logic [31:0] span;
        logic [31:0] remain;
        last_comp = four_bytes ? 2'd3 : 2'd2;
        // alpha (fourth byte) is consumed but not stored
        if (comp_idx < 2'd3) color_acc = color_acc | (24'(b) << {comp_idx, 3'b000});
        if (comp_idx < last_comp) begin
            comp_idx = comp_idx + 2'd1;
            return;
        end
        span = (rle_mode && pkt_run) ? {24'd0, pkt_left} : 32'd1;
        remain = pix_total - pix_done;
        if (span > remain) span = remain;
        add_result(tga_pkg::KIND_SPAN, color_acc, pix_done, span[7:0], '0, '0);
        pix_done = pix_done + span;
        if (rle_mode) begin
            if (pkt_run) pkt_left = '0;
            else if (pkt_left != 0) pkt_left = pkt_left - 8'd1;
        end
        comp_idx = '0;
        color_acc = '0;
        if (pix_done == pix_total) begin
            add_result(tga_pkg::KIND_COMPLETE, '0, pix_done, '0, '0, '0);
            dec_state = ST_IGNORE;
        end else if (rle_mode && pkt_left == 0) begin
            dec_state = ST_PACKET;
        end
    endfunction

    function automatic void decode_byte(tga_pkg::t_in w);
        tga_pkg::t_out tail;
        byte_results.delete();
        case (dec_state)
            ST_HEADER:  take_header_byte(w.data_byte);
            ST_SKIP_ID: begin
                if (id_left != 0) id_left = id_left - 8'd1;
                if (id_left == 0) enter_pixels();
            end
            ST_PACKET: begin
                pkt_left = {1'b0, w.data_byte[6:0]} + 8'd1;
                pkt_run = w.data_byte[7];
                comp_idx = '0;
                color_acc = '0;
                dec_state = ST_PIXEL;
            end
            ST_PIXEL:   take_pixel_byte(w.data_byte);
            default: ;
        endcase
        if (w.end_of_file) begin
            if (dec_state != ST_IGNORE)
                add_result(tga_pkg::KIND_TRUNCATED, '0, pix_done, '0, '0, '0);
            clear_decoder();
        end
        if (byte_results.size() > 0) begin
            tail = byte_results[byte_results.size() - 1];
            tail.last_of_step = 1'b1;
            byte_results[byte_results.size() - 1] = tail;
        end
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_result(input tga_pkg::t_out got);
        tga_pkg::t_out want;
        if (pending_results.size() == 0) begin
            log_mismatch("word with nothing pending, kind", 32'(got.kind), 32'(0));
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind) log_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.red !== want.red) log_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green !== want.green) log_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue) log_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.pixel_index !== want.pixel_index)
            log_mismatch("pixel_index", got.pixel_index, want.pixel_index);
        if (got.run_length !== want.run_length)
            log_mismatch("run_length", 32'(got.run_length), 32'(want.run_length));
        if (got.image_width !== want.image_width)
            log_mismatch("image_width", 32'(got.image_width), 32'(want.image_width));
        if (got.image_height !== want.image_height)
            log_mismatch("image_height", 32'(got.image_height), 32'(want.image_height));
        if (got.last_of_step !== want.last_of_step)
            log_mismatch("last_of_step", 32'(got.last_of_step), 32'(want.last_of_step));
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one word; called at a falling edge, returns at a falling edge
    task automatic send_word(input tga_pkg::t_in w, input logic has_want,
                             input tga_pkg::t_out want);
        int gap;
        i_in <= w;
        i_push <= 1'b1;
        push_high = 1'b1;
        do @(posedge i_clk); while (o_full);
        decode_byte(w);
        if (has_want) pending_results.push_back(want);
        else foreach (byte_results[k]) pending_results.push_back(byte_results[k]);
        words_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            push_high = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic t_dir_row mk_row(logic [7:0] b, logic eof, logic has_want,
                                        logic [2:0] kind, logic [15:0] w, logic [15:0] h);
        t_dir_row row;
        row.word.data_byte = b;
        row.word.end_of_file = eof;
        row.has_want = has_want;
        row.want = '0;
        row.want.kind = kind;
        row.want.image_width = w;
        row.want.image_height = h;
        row.want.last_of_step = 1'b1;
        return row;
    endfunction

    function automatic void load_directed();
        // end of file on the first header byte
        directed_rows.push_back(mk_row(8'h00, 1'b1, 1'b1, tga_pkg::KIND_TRUNCATED, '0, '0));
        // colormap present, file ends on the same byte: no truncation after it
        directed_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'hff, 1'b1, 1'b1, tga_pkg::KIND_UNSUPPORTED, '0, '0));
        // 1x1 run-length 32-bit image, maximal run clipped to one pixel
        directed_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(tga_pkg::TYPE_RLE, 1'b0, 1'b0, tga_pkg::KIND_HEADER,
                                       '0, '0));
        for (int k = 3; k < 12; k++)
            directed_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h01, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h01, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(tga_pkg::BPP_32, 1'b0, 1'b0, tga_pkg::KIND_HEADER,
                                       '0, '0));
        directed_rows.push_back(mk_row(8'hff, 1'b0, 1'b1, tga_pkg::KIND_HEADER,
                                       16'd1, 16'd1));
        directed_rows.push_back(mk_row(8'hff, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'hff, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h80, 1'b0, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
        directed_rows.push_back(mk_row(8'h7f, 1'b1, 1'b0, tga_pkg::KIND_HEADER, '0, '0));
    endfunction

    task automatic build_file();
        int          r;
        int          id_len;
        int          bpp_bytes;
        int          cap;
        int          n;
        int          cut;
        logic [6:0]  cnt;
        logic        run;
        logic        rle;
        logic        four;
        logic        huge;
        logic [7:0]  v;
        logic [15:0] ww;
        logic [15:0] hh;
        logic [31:0] total;
        logic [31:0] done;
        file_bytes.delete();
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 20);
            repeat (n) file_bytes.push_back(8'($urandom));
            return;
        end
        r = $urandom_range(0, 99);
        id_len = (r < 65) ? 0 : (r < 97) ? $urandom_range(1, 4) : $urandom_range(128, 255);
        rle = 1'($urandom_range(0, 1));
        four = 1'($urandom_range(0, 1));
        huge = ($urandom_range(0, 99) < 4);
        if (huge) begin
            ww = $urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(1, 65535));
            hh = $urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(1, 65535));
        end else begin
            ww = 16'($urandom_range(0, 5));
            hh = 16'($urandom_range(0, 5));
        end
        file_bytes.push_back(8'(id_len));
        file_bytes.push_back(8'h00);
        file_bytes.push_back(rle ? tga_pkg::TYPE_RLE : tga_pkg::TYPE_RAW);
        repeat (9) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(ww[7:0]);
        file_bytes.push_back(ww[15:8]);
        file_bytes.push_back(hh[7:0]);
        file_bytes.push_back(hh[15:8]);
        file_bytes.push_back(four ? tga_pkg::BPP_32 : tga_pkg::BPP_24);
        file_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
                0: file_bytes[tga_pkg::HDR_CMAP] = 8'($urandom_range(1, 255));
                1: begin
                    do v = 8'($urandom); while (v == tga_pkg::TYPE_RAW || v == tga_pkg::TYPE_RLE);
                    file_bytes[tga_pkg::HDR_TYPE] = v;
                end
                default: begin
                    do v = 8'($urandom); while (v == tga_pkg::BPP_24 || v == tga_pkg::BPP_32);
                    file_bytes[tga_pkg::HDR_BPP] = v;
                end
            endcase
        end
        repeat (id_len) file_bytes.push_back(8'($urandom));
        total = {16'd0, ww} * {16'd0, hh};
        done = '0;
        bpp_bytes = four ? 4 : 3;
        cap = file_bytes.size() + 60;
        while (done < total && file_bytes.size() < cap) begin
            n = 1;
            if (rle) begin
                cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 3));
                run = 1'($urandom_range(0, 1));
                file_bytes.push_back({run, cnt});
                if (!run) n = ({25'd0, cnt} + 1 > total - done) ? int'(total - done) : cnt + 1;
                done = run ? done + cnt + 1 : done + n;
                if (done > total) done = total;
            end else begin
                done = done + 1;
            end
            repeat (n * bpp_bytes) file_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 99) < 20) begin
            n = $urandom_range(1, 4);
            repeat (n) file_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 99) < 12) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
    endtask

    // pop side: random stalls, every accepted word checked
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && o_empty === 1'b0) check_result(o_out);
            @(negedge i_clk);
            if (stall > 0) stall--;
            else stall = pick_gap();
            i_pop <= (stall == 0);
        end
    end

    initial begin
        tga_pkg::t_in w;
        clear_decoder();
        load_directed();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_rows[k])
            send_word(directed_rows[k].word, directed_rows[k].has_want, directed_rows[k].want);
        while (words_sent < 1300) begin
            if ($urandom_range(0, 99) < 15) calm = ~calm;
            build_file();
            foreach (file_bytes[k]) begin
                w.data_byte = file_bytes[k];
                w.end_of_file = (k == file_bytes.size() - 1);
                send_word(w, 1'b0, '0);
            end
        end
        if (push_high) i_push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tga_pkg.sv
sv/tga_front.sv
sv/tga_fifo.sv
sv/tga_back.sv
sv/tga_rle_image_decoder.sv
sv/tga_chk.sv
tb/sv/tga_rle_image_decoder_test.sv
